// File: design/gcc_pkg.sv
// Shared types, codes and sizes for the graph component and cycle checker.
`default_nettype none

package gcc_pkg;

	// Field widths fixed by the item format
	localparam int VERTEX_W = 5;
	localparam int ROW_W    = 32;
	localparam int COUNT_W  = 6;

	localparam int DEFAULT_MAX_VERTICES = 32;

	// Parent link of a root vertex
	localparam logic [COUNT_W-1:0] PARENT_NONE = 6'd63;

	// Operation codes
	localparam logic [1:0] OP_CLEAR    = 2'd0;
	localparam logic [1:0] OP_ADD_EDGE = 2'd1;
	localparam logic [1:0] OP_RUN      = 2'd2;

	// Result kinds
	localparam logic KIND_VERTEX  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [1:0]          operation;
		logic [VERTEX_W-1:0] endpoint_a;
		logic [VERTEX_W-1:0] endpoint_b;
	} in_item_t;

	typedef struct packed {
		logic                kind;
		logic [VERTEX_W-1:0] vertex;
		logic [COUNT_W-1:0]  component_index;
		logic                last_in_component;
		logic [COUNT_W-1:0]  component_count;
		logic                graph_connected;
		logic                graph_cyclic;
		logic                last;
	} out_item_t;

	// Request to the adjacency row store
	typedef struct packed {
		logic                clear;
		logic                wr_en;
		logic [VERTEX_W-1:0] wr_addr;
		logic [ROW_W-1:0]    wr_data;
		logic                rd_en;
		logic [VERTEX_W-1:0] rd_addr;
	} adj_cmd_t;

endpackage

`default_nettype wire

// File: design/gcc_adj_mem.sv
// Adjacency row store: registered read, per-row valid bits so that a clear drops every row at once.
`default_nettype none

module gcc_adj_mem #(
	parameter int ROWS = gcc_pkg::DEFAULT_MAX_VERTICES
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire gcc_pkg::adj_cmd_t       cmd,
	output logic [gcc_pkg::ROW_W-1:0]    rd_row
);
	import gcc_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]  row_vld_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_vld_q;

	// Row storage and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr[RW-1:0]] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_addr[RW-1:0]];
		end
	end

	// Track which rows hold written data; a clear drops them all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				row_vld_q <= '0;
			end else if (cmd.wr_en) begin
				row_vld_q[cmd.wr_addr[RW-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= row_vld_q[cmd.rd_addr[RW-1:0]];
			end
		end
	end

	// A row never written reads as empty
	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: design/graph_components_and_cycle_check.sv
// Top level: depth-first component walk and cycle check over an adjacency matrix.
//
//   port group            direction  handshake           carries
//   in_valid/in_ready     in         valid/ready         in_item_t: operation, endpoints
//   out_valid/out_ready   out        valid/ready         out_item_t: vertex or summary
//   cfg_wr_en/cfg_wr_data in         write, no wait      vertex_count
//
// An edge add does two read-modify-writes of the row store (S_ADD_WA, S_ADD_RB, S_ADD_WB).
// During a run each vertex row is loaded from the row store and scanned one neighbour
// a cycle unless a descent waits for the output register, and each return to a parent
// costs a stack read and a row reload.
// Reset empties the matrix at once through per-row valid bits.
// A full output register stalls the walk; the next item is taken after the summary
// has been loaded into the output register.
`default_nettype none

module graph_components_and_cycle_check #(
	parameter int MAX_VERTICES = gcc_pkg::DEFAULT_MAX_VERTICES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire gcc_pkg::in_item_t           in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output gcc_pkg::out_item_t               out_data,
	input  wire logic                        cfg_wr_en,
	input  wire logic [gcc_pkg::COUNT_W-1:0] cfg_wr_data
);
	import gcc_pkg::*;

	localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [COUNT_W-1:0] ROWS_C = COUNT_W'(ROWS);
	localparam logic [COUNT_W-1:0] MAX_C  = COUNT_W'(MAX_VERTICES);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_WA, S_ADD_RB, S_ADD_WB,
		S_ROOT, S_LOAD, S_SCAN, S_POP, S_ENDC, S_SUM
	} state_t;

	// One level of the walk: vertex, next neighbour to try, parent
	typedef struct packed {
		logic [COUNT_W-1:0]  parent;
		logic [COUNT_W-1:0]  next;
		logic [VERTEX_W-1:0] vtx;
	} frame_t;

	state_t              state_q;
	logic [COUNT_W-1:0]  vertex_count_q;
	logic [VERTEX_W-1:0] a_q, b_q;
	logic [ROWS-1:0]     visited_q;
	logic [COUNT_W-1:0]  root_q;
	logic [COUNT_W-1:0]  comp_q;
	logic                cyc_q;
	logic [RW-1:0]       depth_q;
	frame_t              cur_q;
	logic [ROW_W-1:0]    row_q;
	logic [VERTEX_W-1:0] pend_v_q;
	logic                out_valid_q;
	out_item_t           out_q;

	frame_t              stack_mem [ROWS];
	frame_t              stk_rd_q;

	adj_cmd_t            adj_cmd;
	logic [ROW_W-1:0]    adj_row;

	logic [COUNT_W-1:0]  n;
	logic                in_xfer;
	logic                out_free;
	logic                out_load;
	logic                add_ok;
	logic [COUNT_W-1:0]  idx;
	logic                at_end;
	logic                hit;
	logic                new_vtx;
	logic                visit_go;
	logic                root_done;
	logic                root_new;
	logic                pop_go;

	gcc_adj_mem #(
		.ROWS (ROWS)
	) u_adj (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (adj_cmd),
		.rd_row (adj_row)
	);

	// Walk limit and handshake terms
	assign n        = (vertex_count_q > ROWS_C) ? ROWS_C : vertex_count_q;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign add_ok   = ({1'b0, in_data.endpoint_a} < MAX_C) &&
	                  ({1'b0, in_data.endpoint_b} < MAX_C);

	// Scan of the current row, one neighbour a cycle unless a descent waits for the output register
	assign idx      = cur_q.next;
	assign at_end   = (idx >= n);
	assign hit      = !at_end && row_q[idx[VERTEX_W-1:0]];
	assign new_vtx  = hit && !visited_q[idx[RW-1:0]];
	assign visit_go = (state_q == S_SCAN) && new_vtx && out_free;
	assign pop_go   = (state_q == S_SCAN) && at_end && (depth_q != '0);

	// Load the output register on a descent, a component end or the summary
	assign out_load = visit_go || (out_free && (state_q == S_ENDC || state_q == S_SUM));

	// Root search in ascending order
	assign root_done = (root_q >= n);
	assign root_new  = !root_done && !visited_q[root_q[RW-1:0]];

	// Drive the row store
	always_comb begin
		adj_cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && in_data.operation == OP_CLEAR) begin
					adj_cmd.clear = 1'b1;
				end
				if (in_xfer && in_data.operation == OP_ADD_EDGE && add_ok) begin
					adj_cmd.rd_en   = 1'b1;
					adj_cmd.rd_addr = in_data.endpoint_a;
				end
			end
			S_ADD_WA: begin
				adj_cmd.wr_en   = 1'b1;
				adj_cmd.wr_addr = a_q;
				adj_cmd.wr_data = adj_row | (ROW_W'(1) << b_q);
			end
			S_ADD_RB: begin
				adj_cmd.rd_en   = 1'b1;
				adj_cmd.rd_addr = b_q;
			end
			S_ADD_WB: begin
				adj_cmd.wr_en   = 1'b1;
				adj_cmd.wr_addr = b_q;
				adj_cmd.wr_data = adj_row | (ROW_W'(1) << a_q);
			end
			S_ROOT: begin
				adj_cmd.rd_en   = root_new;
				adj_cmd.rd_addr = root_q[VERTEX_W-1:0];
			end
			S_SCAN: begin
				adj_cmd.rd_en   = visit_go;
				adj_cmd.rd_addr = idx[VERTEX_W-1:0];
			end
			S_POP: begin
				adj_cmd.rd_en   = 1'b1;
				adj_cmd.rd_addr = stk_rd_q.vtx;
			end
			default: begin
				adj_cmd = '0;
			end
		endcase
	end

	// Walk stack: push on descent, registered read on return
	always_ff @(posedge clk) begin
		if (visit_go) begin
			stack_mem[depth_q] <= '{parent: cur_q.parent, next: idx + 1'b1, vtx: cur_q.vtx};
		end
		if (pop_go) begin
			stk_rd_q <= stack_mem[depth_q - 1'b1];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// Sequencer, walk state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			visited_q   <= '0;
			root_q      <= '0;
			comp_q      <= '0;
			cyc_q       <= 1'b0;
			depth_q     <= '0;
			cur_q       <= '0;
			row_q       <= '0;
			pend_v_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						a_q <= in_data.endpoint_a;
						b_q <= in_data.endpoint_b;
						if (in_data.operation == OP_ADD_EDGE && add_ok) begin
							state_q <= S_ADD_WA;
						end else if (in_data.operation == OP_RUN) begin
							visited_q <= '0;
							root_q    <= '0;
							comp_q    <= '0;
							cyc_q     <= 1'b0;
							depth_q   <= '0;
							state_q   <= S_ROOT;
						end
					end
				end
				S_ADD_WA: begin
					state_q <= S_ADD_RB;
				end
				S_ADD_RB: begin
					state_q <= S_ADD_WB;
				end
				S_ADD_WB: begin
					state_q <= S_IDLE;
				end
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_SUM;
					end else if (root_new) begin
						comp_q                   <= comp_q + 1'b1;
						visited_q[root_q[RW-1:0]] <= 1'b1;
						cur_q    <= '{parent: PARENT_NONE, next: '0, vtx: root_q[VERTEX_W-1:0]};
						pend_v_q <= root_q[VERTEX_W-1:0];
						state_q  <= S_LOAD;
					end else begin
						root_q <= root_q + 1'b1;
					end
				end
				S_LOAD: begin
					row_q   <= adj_row;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (at_end) begin
						if (pop_go) begin
							depth_q <= depth_q - 1'b1;
							state_q <= S_POP;
						end else begin
							state_q <= S_ENDC;
						end
					end else if (visit_go) begin
						// Hand over the previous vertex, descend into the new one
						out_q <= '{kind: KIND_VERTEX, vertex: pend_v_q, component_index: comp_q,
						           last_in_component: 1'b0, component_count: '0,
						           graph_connected: 1'b0, graph_cyclic: 1'b0, last: 1'b0};
						pend_v_q              <= idx[VERTEX_W-1:0];
						visited_q[idx[RW-1:0]] <= 1'b1;
						depth_q               <= depth_q + 1'b1;
						cur_q <= '{parent: {1'b0, cur_q.vtx}, next: '0, vtx: idx[VERTEX_W-1:0]};
						state_q <= S_LOAD;
					end else if (!new_vtx) begin
						if (hit && idx != cur_q.parent) begin
							cyc_q <= 1'b1;
						end
						cur_q.next <= idx + 1'b1;
					end
				end
				S_POP: begin
					cur_q   <= stk_rd_q;
					state_q <= S_LOAD;
				end
				S_ENDC: begin
					if (out_free) begin
						out_q <= '{kind: KIND_VERTEX, vertex: pend_v_q, component_index: comp_q,
						           last_in_component: 1'b1, component_count: '0,
						           graph_connected: 1'b0, graph_cyclic: 1'b0, last: 1'b0};
						root_q  <= root_q + 1'b1;
						state_q <= S_ROOT;
					end
				end
				S_SUM: begin
					if (out_free) begin
						out_q <= '{kind: KIND_SUMMARY, vertex: '0, component_index: '0,
						           last_in_component: 1'b0, component_count: comp_q,
						           graph_connected: (comp_q == COUNT_W'(1)),
						           graph_cyclic: cyc_q, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The vertex under scan has always been marked
	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> visited_q[cur_q.vtx[RW-1:0]])
		else $error("current vertex not marked visited");

	// Stored levels stay below the walk limit
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (COUNT_W'(depth_q) < n))
		else $error("walk stack deeper than the vertex count");

	// A row load follows a root start, a descent or a return only
	a_load_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |->
		($past(state_q) == S_ROOT || $past(state_q) == S_SCAN || $past(state_q) == S_POP))
		else $error("row load without a request");

	// No more components than vertices walked
	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (comp_q <= n))
		else $error("component count above the walk limit");

endmodule

`default_nettype wire
